[rtl/pud_pkg.sv]
package pud_pkg;

  localparam logic [7:0] PCT_CHAR = 8'h25;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UZ    = 8'h5a;

  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_PCT  = 2'd1;
  localparam logic [1:0] PH_HELD = 2'd2;

  localparam int unsigned QDEPTH = 3;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [15:0] count;
  } beat_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LZ) ||
           (c >= CH_UA && c <= CH_UZ);
  endfunction

  // Bit 4 set means the character is not a hex digit.
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= CH_0 && c <= CH_9) begin
      v = 5'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LF) begin
      v = 5'(c - CH_LA + 8'd10);
    end else if (c >= CH_UA && c <= CH_UF) begin
      v = 5'(c - CH_UA + 8'd10);
    end
    return v;
  endfunction

  function automatic logic [7:0] decode_pair(input logic [7:0] c1, input logic [7:0] c2);
    logic [4:0] h1;
    logic [4:0] h2;
    logic [7:0] v;
    h1 = hex_of(c1);
    h2 = hex_of(c2);
    if (h1[4]) begin
      v = 8'h00;
    end else if (h2[4]) begin
      v = {4'h0, h1[3:0]};
    end else begin
      v = {h1[3:0], h2[3:0]};
    end
    return v;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] x);
    return (x == 16'hffff) ? x : x + 16'd1;
  endfunction

endpackage

[rtl/percent_url_decoder_core.sv]
// Percent decoder for escaped strings. One byte beat is taken per cycle; a beat
// can yield zero to three output beats, which drain from a three-entry result
// queue at one per cycle while the output side is not stalled, so input stalls
// only while a broken escape flushes more than one byte or the output side
// stalls. Results appear in the cycle after the input beat is taken.
module percent_url_decoder_core
  import pud_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [15:0] out_count
);

  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [15:0] prod_r, prod_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  beat_t       q_r [QDEPTH];
  beat_t       q_nxt [QDEPTH];

  beat_t       new_q [QDEPTH];
  logic [1:0]  new_n;
  logic        pop, push;
  logic [15:0] c1, c2, c3;

  assign out_valid = (cnt_r != 2'd0);
  assign out_byte  = q_r[0].data;
  assign out_last  = q_r[0].last;
  assign out_count = q_r[0].count;
  assign pop       = out_valid && !out_stall;
  assign in_stall  = (cnt_r > 2'd1) || ((cnt_r == 2'd1) && out_stall);
  assign push      = in_valid && !in_stall;

  assign c1 = sat_inc(prod_r);
  assign c2 = sat_inc(c1);
  assign c3 = sat_inc(c2);

  always_comb begin
    logic fresh_emit;
    logic fresh_pct;
    logic [1:0] npre;
    fresh_pct  = (in_byte == PCT_CHAR) && !in_last;
    fresh_emit = !fresh_pct;
    npre       = 2'd0;
    phase_nxt  = phase_r;
    held_nxt   = held_r;
    for (int i = 0; i < QDEPTH; i++) begin
      new_q[i] = '{data: in_byte, last: in_last, count: c1};
    end
    new_q[1].count = c2;
    new_q[2].count = c3;
    case (phase_r)
      PH_PCT: begin
        if (is_alnum(in_byte) && !in_last) begin
          fresh_emit = 1'b0;
          held_nxt   = in_byte;
          phase_nxt  = PH_HELD;
        end else begin
          npre      = 2'd1;
          phase_nxt = fresh_pct ? PH_PCT : PH_NONE;
        end
      end
      PH_HELD: begin
        if (is_alnum(in_byte)) begin
          fresh_emit = 1'b0;
          npre       = 2'd0;
          new_q[0].data = decode_pair(held_r, in_byte);
          new_q[0].last = in_last;
          phase_nxt  = PH_NONE;
        end else begin
          npre      = 2'd2;
          phase_nxt = fresh_pct ? PH_PCT : PH_NONE;
        end
      end
      default: begin
        phase_nxt = fresh_pct ? PH_PCT : PH_NONE;
      end
    endcase
    if (npre != 2'd0) begin
      new_q[0].data = PCT_CHAR;
      new_q[0].last = 1'b0;
    end
    if (npre == 2'd2) begin
      new_q[1].data = held_r;
      new_q[1].last = 1'b0;
    end
    if (phase_r == PH_HELD && is_alnum(in_byte)) begin
      new_n = 2'd1;
    end else begin
      new_n = npre + {1'b0, fresh_emit};
    end
    case (new_n)
      2'd1:    prod_nxt = c1;
      2'd2:    prod_nxt = c2;
      2'd3:    prod_nxt = c3;
      default: prod_nxt = prod_r;
    endcase
    if (in_last) begin
      phase_nxt = PH_NONE;
      held_nxt  = 8'h00;
      prod_nxt  = 16'h0000;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (push) begin
      cnt_nxt = new_n;
      for (int i = 0; i < QDEPTH; i++) begin
        q_nxt[i] = new_q[i];
      end
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NONE;
      held_r  <= 8'h00;
      prod_r  <= 16'h0000;
      cnt_r   <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
        prod_r  <= prod_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

[rtl/pud_checker.sv]
module pud_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        out_last,
  input logic [15:0] out_count
);

  // A stalled output beat stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last)
      && $stable(out_count))
    else $error("stalled output beat changed");

  // The input side is only held off while results are pending.
  a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count != 16'd0)
    else $error("output count is zero");

  // A beat that directly follows the end of a string opens a new one.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last |=> !out_valid || out_count == 16'd1)
    else $error("output count not restarted after last beat");

endmodule

bind percent_url_decoder_core pud_checker u_pud_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .out_last  (out_last),
  .out_count (out_count)
);
